// ----- hw/rtl/multi_queue_bounded_deque_macros.svh -----
// Assertion helpers for the queue bank checker.
`ifndef MULTI_QUEUE_BOUNDED_DEQUE_MACROS_SVH
`define MULTI_QUEUE_BOUNDED_DEQUE_MACROS_SVH

// Same-cycle implication.
`define MQBD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mqbd check failed: %m");

// Next-cycle implication.
`define MQBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mqbd check failed: %m");

`endif

// ----- hw/rtl/mqbd_pkg.sv -----
`default_nettype none

package mqbd_pkg;

   // Default sizes
   localparam int NUM_QUEUES_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int ID_WIDTH_DEF    = 16;

   // Fixed payload widths
   localparam int QIDX_W     = 5;
   localparam int ENTRY_ID_W = 16;
   localparam int COUNT_W    = 4;
   localparam int STATUS_W   = 2;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ADDED  = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_SERVED = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   // Operation codes
   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TAKE = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_LOOKUP,
      CTL_DONE
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic lookup;
      logic load_out;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic clr_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mqbd_ifs.sv -----
`default_nettype none

// Request channel
interface mqbd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [mqbd_pkg::QIDX_W-1:0]     queue_index;
   logic [mqbd_pkg::ENTRY_ID_W-1:0] entry_id;
   logic                            urgent;

   modport source (output valid, mode, queue_index, entry_id, urgent, input ready);
   modport sink (input valid, mode, queue_index, entry_id, urgent, output ready);
endinterface

// Response channel
interface mqbd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mqbd_pkg::STATUS_W-1:0]   result_status;
   logic [mqbd_pkg::ENTRY_ID_W-1:0] served_id;
   logic                            served_urgent;
   logic [mqbd_pkg::COUNT_W-1:0]    queue_count;

   modport source (output valid, result_status, served_id, served_urgent, queue_count,
                   input ready);
   modport sink (input valid, result_status, served_id, served_urgent, queue_count,
                 output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mqbd_ctrl.sv -----
`default_nettype none

module mqbd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mqbd_pkg::dp_status_type sts,
   output mqbd_pkg::dp_cmd_type         cmd
);
   import mqbd_pkg::*;

   ctl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_CLEAR:  if (sts.clr_done) state_in = CTL_IDLE;
         CTL_IDLE:   if (sts.req_valid) state_in = CTL_LOOKUP;
         CTL_LOOKUP: state_in = CTL_DONE;
         CTL_DONE:   if (sts.out_free) state_in = CTL_IDLE;
         default:    state_in = CTL_CLEAR;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         CTL_CLEAR:  cmd.clear = 1'b1;
         CTL_IDLE:   cmd.accept = 1'b1;
         CTL_LOOKUP: cmd.lookup = 1'b1;
         CTL_DONE:   cmd.load_out = sts.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mqbd_datapath.sv -----
`default_nettype none

module mqbd_datapath #(
   parameter int NUM_QUEUES  = mqbd_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = mqbd_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = mqbd_pkg::ID_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mqbd_pkg::dp_cmd_type cmd,
   output mqbd_pkg::dp_status_type   sts,
   mqbd_req_if.sink                  req_port,
   mqbd_rsp_if.source                rsp_port
);
   import mqbd_pkg::*;

   localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW    = $clog2(QUEUE_DEPTH + 1);
   localparam int NENT  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW    = (NENT > 1) ? $clog2(NENT) : 1;
   localparam int SIDW  = (ID_WIDTH < ENTRY_ID_W) ? ID_WIDTH : ENTRY_ID_W;
   localparam int QSW   = SW + LW;
   localparam int NIDX  = 1 << QIDX_W;

   // Queue index reduced modulo the bank size
   logic [QW-1:0] qmod_lut [NIDX];
   for (genvar g = 0; g < NIDX; g++) begin : g_qmod
      assign qmod_lut[g] = QW'(g % NUM_QUEUES);
   end

   logic xfer_in;
   assign xfer_in = cmd.accept && req_port.valid;
   assign req_port.ready = cmd.accept;

   // Captured request
   logic            op_mode_ff;
   logic [QW-1:0]   op_q_ff;
   logic [SIDW-1:0] op_id_ff;
   logic            op_urg_ff;

   always_ff @(posedge clock) begin
      if (xfer_in) begin
         op_mode_ff <= req_port.mode;
         op_q_ff    <= qmod_lut[req_port.queue_index];
         op_id_ff   <= req_port.entry_id[SIDW-1:0];
         op_urg_ff  <= req_port.urgent;
      end
   end

   // Clear sweep over the queue state memory
   logic [QW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Queue state memory: {head, length}
   logic [QSW-1:0] qs_mem [NUM_QUEUES];
   logic [QSW-1:0] qs_rd_ff;
   logic [QSW-1:0] qs_wr;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         qs_mem[clr_ff] <= '0;
      end else if (cmd.lookup) begin
         qs_mem[op_q_ff] <= qs_wr;
      end
      if (xfer_in) begin
         qs_rd_ff <= qs_mem[qmod_lut[req_port.queue_index]];
      end
   end

   // Pointer arithmetic
   logic [SW-1:0] head, head_dec, head_inc, tail, slot, head_new;
   logic [LW-1:0] len, len_new;
   logic [SW:0]   tail_sum;
   logic          full, empty, do_add, do_take;
   status_type    status;
   logic [AW-1:0] addr;

   always_comb begin
      head     = qs_rd_ff[QSW-1:LW];
      len      = qs_rd_ff[LW-1:0];
      full     = (len >= LW'(QUEUE_DEPTH));
      empty    = (len == '0);
      head_dec = (head == '0) ? SW'(QUEUE_DEPTH - 1) : head - 1'b1;
      head_inc = (head == SW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      tail_sum = (SW+1)'(head) + (SW+1)'(len);
      tail     = (tail_sum >= (SW+1)'(QUEUE_DEPTH)) ?
                 SW'(tail_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(tail_sum);
      do_add   = (op_mode_ff == MODE_ADD) && !full;
      do_take  = (op_mode_ff == MODE_TAKE) && !empty;

      slot     = head;
      head_new = head;
      len_new  = len;
      if (op_mode_ff == MODE_ADD) begin
         status = full ? STATUS_FULL : STATUS_ADDED;
         slot   = op_urg_ff ? head_dec : tail;
         if (do_add) begin
            head_new = op_urg_ff ? head_dec : head;
            len_new  = len + 1'b1;
         end
      end else begin
         status = empty ? STATUS_EMPTY : STATUS_SERVED;
         if (do_take) begin
            head_new = head_inc;
            len_new  = len - 1'b1;
         end
      end
      qs_wr = {head_new, len_new};
      addr  = AW'(32'(op_q_ff) * QUEUE_DEPTH + 32'(slot));
   end

   // Entry memory: {urgent, id}
   logic [SIDW:0] ent_mem [NENT];
   logic [SIDW:0] ent_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.lookup && do_add) begin
         ent_mem[addr] <= {op_urg_ff, op_id_ff};
      end
      if (cmd.lookup && do_take) begin
         ent_rd_ff <= ent_mem[addr];
      end
   end

   // Result held until the output register is free
   status_type    status_ff;
   logic [LW-1:0] count_ff;
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         status_ff <= status;
         count_ff  <= len_new;
      end
   end

   // Output register
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ENTRY_ID_W-1:0] rsp_id_ff;
   logic                  rsp_urg_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  served;

   assign served = (status_ff == STATUS_SERVED);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_id_ff     <= served ? ENTRY_ID_W'(ent_rd_ff[SIDW-1:0]) : '0;
         rsp_urg_ff    <= served ? ent_rd_ff[SIDW] : 1'b0;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.result_status = rsp_status_ff;
   assign rsp_port.served_id     = rsp_id_ff;
   assign rsp_port.served_urgent = rsp_urg_ff;
   assign rsp_port.queue_count   = rsp_count_ff;

   // Status to controller
   assign sts.req_valid = req_port.valid;
   assign sts.out_free  = !rsp_valid_ff || rsp_port.ready;
   assign sts.clr_done  = (clr_ff == QW'(NUM_QUEUES - 1));

endmodule

`default_nettype wire

// ----- hw/rtl/multi_queue_bounded_deque.sv -----
// Bank of bounded queues, one per class index.
// Request channel (req_port): mode 0 adds entry_id to queue queue_index, at the
// front when urgent is set, else at the back; mode 1 pops the front entry.
// Response channel (rsp_port): one result per request with status (added,
// rejected full, served, queue empty), the popped id and urgent flag, and the
// queue length after the operation.
// Both channels move a transfer when valid and ready are high at a clock edge.
// Steps per request: registered read of the queue state memory, entry memory
// access with the queue state update, and the output register load, which waits
// while the output register is still full; one request is in flight at a time,
// so a new request is not taken until the last one has loaded its response.
// Reset: after reset is released the per-queue head/length memory is swept to
// zero, one queue per cycle (NUM_QUEUES cycles), with req_port.ready low.
// Entry storage is not cleared; only entries written earlier are ever read.
// Stall: the response waits in an output register; the next request is still
// taken and its result held until the response register frees up.
`default_nettype none

module multi_queue_bounded_deque #(
   parameter int NUM_QUEUES  = mqbd_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = mqbd_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = mqbd_pkg::ID_WIDTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   mqbd_req_if.sink   req_port,
   mqbd_rsp_if.source rsp_port
);
   import mqbd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   mqbd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   mqbd_datapath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/mqbd_checker.sv -----
`default_nettype none

`include "multi_queue_bounded_deque_macros.svh"

module mqbd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mqbd_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [mqbd_pkg::ENTRY_ID_W-1:0] rsp_id,
   input wire logic                            rsp_urgent,
   input wire logic [mqbd_pkg::COUNT_W-1:0]    rsp_count
);
   import mqbd_pkg::*;

   // Stalled response keeps its contents
   `MQBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_id) && $stable(rsp_urgent) && $stable(rsp_count))

   // Add results carry no popped entry
   `MQBD_ASSERT_NOW(a_add_no_entry, clock, reset, rsp_valid && (rsp_status == STATUS_ADDED || rsp_status == STATUS_FULL), rsp_id == '0 && !rsp_urgent)

   // Empty take leaves an empty queue
   `MQBD_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_count == '0)

   // Clear sweep blocks requests right after reset
   `MQBD_ASSERT_NEXT(a_clear_blocks, clock, 1'b0, reset, !req_ready)

   // One request in flight at a time
   `MQBD_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind multi_queue_bounded_deque mqbd_checker u_mqbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_status (rsp_port.result_status),
   .rsp_id     (rsp_port.served_id),
   .rsp_urgent (rsp_port.served_urgent),
   .rsp_count  (rsp_port.queue_count)
);

`default_nettype wire
